>>> rtl/inclusive_date_day_count_macros.svh
// ============================================================================
// Assertion macros for the inclusive date day count block
// Short forms for clocked properties with reset disable, same cycle or next.
// ============================================================================
`ifndef INCLUSIVE_DATE_DAY_COUNT_MACROS_SVH
`define INCLUSIVE_DATE_DAY_COUNT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IDDC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IDDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/iddc_pkg.sv
// ============================================================================
// iddc_pkg
// Widths, reciprocal constants and calendar tables for the day count block.
// ============================================================================
package iddc_pkg;

    localparam int DATE_W  = 27;
    localparam int COUNT_W = 22;
    localparam int NUM_W   = 23;
    localparam int STAGES  = 10;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 22'h3FFFFF;

    // Reciprocals of 100 for the three operand sizes. The first two are the
    // floor of 2^k / 100 and need one correction step after the multiply.
    // The third is rounded up, which gives the exact quotient for every
    // shifted year without a correction.
    localparam int              RECIP1_SH = 34;
    localparam logic [27:0]     RECIP1    = 28'd171798691;
    localparam int              RECIP2_SH = 27;
    localparam logic [20:0]     RECIP2    = 21'd1342177;
    localparam int              RECIP3_SH = 24;
    localparam logic [17:0]     RECIP3    = 18'd167773;

    // Year offset of one whole Gregorian cycle minus one.
    localparam logic [13:0] YEAR_OFS = 14'd399;

    // Days in the year before the first of the month; zero for bad months.
    function automatic logic [8:0] days_before(input logic [6:0] m);
        logic [8:0] r;
        case (m)
            7'd1:    r = 9'd0;
            7'd2:    r = 9'd31;
            7'd3:    r = 9'd59;
            7'd4:    r = 9'd90;
            7'd5:    r = 9'd120;
            7'd6:    r = 9'd151;
            7'd7:    r = 9'd181;
            7'd8:    r = 9'd212;
            7'd9:    r = 9'd243;
            7'd10:   r = 9'd273;
            7'd11:   r = 9'd304;
            7'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Length of a month; months outside the year fall to 31.
    function automatic logic [4:0] month_len(input logic [6:0] m, input logic leap);
        logic [4:0] r;
        if (m == 7'd2)
            r = leap ? 5'd29 : 5'd28;
        else if (m inside {7'd4, 7'd6, 7'd9, 7'd11})
            r = 5'd30;
        else
            r = 5'd31;
        return r;
    endfunction

endpackage

>>> rtl/inclusive_date_day_count.sv
// ============================================================================
// inclusive_date_day_count
// Inclusive Gregorian day count between two YYYYMMDD dates.
// ============================================================================
// The block takes one pair of dates per beat and returns one result per
// beat, sustaining one pair every clock cycle whenever the output is not
// stalled, and each result is registered at the output. Each date is
// a binary integer holding decimal YYYYMMDD; the two may come in either
// order. The result is the number of days from the earlier to the later date
// counting both ends, saturated to 22 bits. A bad month or day on either
// side gives count zero with the invalid flag set. The ten-stage pipeline
// advances as one: it moves whenever the output register is empty or being
// taken, so a stall on the output holds every stage in place.
module inclusive_date_day_count
    import iddc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [26:0] date_first, [53:27] date_second, [55:54] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [21:0] day_count, [23:22] zero
    output logic        m_tuser    // [0] date_invalid
);

    logic adv;
    logic [STAGES-1:0] vld_reg, vld_next;

    // Per-date pipeline payload.
    logic [DATE_W-1:0] x0_reg  [2];
    logic [DATE_W-1:0] x1_reg  [2];
    logic [20:0]       qe1_reg [2];
    logic [20:0]       q2_reg  [2];
    logic [6:0]        d2_reg  [2];
    logic [20:0]       q3_reg  [2];
    logic [13:0]       qe3_reg [2];
    logic [6:0]        d3_reg  [2];
    logic [13:0]       y4_reg  [2];
    logic [6:0]        m4_reg  [2];
    logic [6:0]        d4_reg  [2];
    logic [13:0]       y5_reg  [2];
    logic [13:0]       p5_reg  [2];
    logic [6:0]        m5_reg  [2];
    logic [6:0]        d5_reg  [2];
    logic [NUM_W-1:0]  p365_reg [2];
    logic [7:0]        pc5_reg [2];
    logic [7:0]        yc5_reg [2];
    logic [NUM_W-1:0]  base6_reg [2];
    logic [8:0]        mo6_reg [2];
    logic              ok6_reg [2];
    logic [NUM_W-1:0]  n7_reg  [2];
    logic              bad7_reg, bad8_reg;
    logic [NUM_W-1:0]  diff8_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic               inv_reg;

    // Next values.
    logic [20:0]       qe1_next  [2];
    logic [20:0]       q2_next   [2];
    logic [6:0]        d2_next   [2];
    logic [13:0]       qe3_next  [2];
    logic [13:0]       y4_next   [2];
    logic [6:0]        m4_next   [2];
    logic [13:0]       p5_next   [2];
    logic [NUM_W-1:0]  p365_next [2];
    logic [7:0]        pc5_next  [2];
    logic [7:0]        yc5_next  [2];
    logic [NUM_W-1:0]  base6_next [2];
    logic [8:0]        mo6_next  [2];
    logic              ok6_next  [2];
    logic [NUM_W-1:0]  n7_next   [2];
    logic [NUM_W-1:0]  diff8_next;
    logic [COUNT_W-1:0] cnt_next;

    // Temporaries.
    logic [54:0]       prod1 [2];
    logic [DATE_W-1:0] r1    [2];
    logic [41:0]       prod2 [2];
    logic [20:0]       r2    [2];
    logic [31:0]       prodp [2];
    logic [31:0]       prody [2];
    logic [13:0]       yc100 [2];
    logic              cent  [2];
    logic              leap  [2];
    logic [23:0]       cnt_wide;

    // The whole pipeline moves when the output register is free.
    assign adv      = !vld_reg[STAGES-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[STAGES-1];
    assign m_tdata  = {2'b00, cnt_reg};
    assign m_tuser  = inv_reg;
    assign vld_next = {vld_reg[STAGES-2:0], s_tvalid};

    // Date splitting and day numbering, one lane per date.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            // Stage 1: estimate of date / 100.
            prod1[i]    = {27'd0, x0_reg[i]} * {27'd0, RECIP1};
            qe1_next[i] = prod1[i][RECIP1_SH+20:RECIP1_SH];

            // Stage 2: remainder with one correction gives the day.
            r1[i] = x1_reg[i] - ({6'd0, qe1_reg[i]} * 27'd100);
            if (r1[i][7:0] >= 8'd100)
            begin
                d2_next[i] = 7'(r1[i][7:0] - 8'd100);
                q2_next[i] = qe1_reg[i] + 21'd1;
            end
            else
            begin
                d2_next[i] = r1[i][6:0];
                q2_next[i] = qe1_reg[i];
            end

            // Stage 3: estimate of (date / 100) / 100.
            prod2[i]    = {21'd0, q2_reg[i]} * {21'd0, RECIP2};
            qe3_next[i] = prod2[i][RECIP2_SH+13:RECIP2_SH];

            // Stage 4: remainder with one correction gives the month.
            r2[i] = q3_reg[i] - ({7'd0, qe3_reg[i]} * 21'd100);
            if (r2[i][7:0] >= 8'd100)
            begin
                m4_next[i] = 7'(r2[i][7:0] - 8'd100);
                y4_next[i] = qe3_reg[i] + 14'd1;
            end
            else
            begin
                m4_next[i] = r2[i][6:0];
                y4_next[i] = qe3_reg[i];
            end

            // Stage 5: shifted year, its centuries, and whole-year days.
            p5_next[i]   = y4_reg[i] + YEAR_OFS;
            prodp[i]     = {18'd0, p5_next[i]} * {14'd0, RECIP3};
            prody[i]     = {18'd0, y4_reg[i]} * {14'd0, RECIP3};
            pc5_next[i]  = prodp[i][RECIP3_SH+7:RECIP3_SH];
            yc5_next[i]  = prody[i][RECIP3_SH+7:RECIP3_SH];
            p365_next[i] = {9'd0, p5_next[i]} * 23'd365;

            // Stage 6: leap rule, field check, and the two partial sums.
            yc100[i] = {6'd0, yc5_reg[i]} * 14'd100;
            cent[i]  = (y5_reg[i] == yc100[i]);
            leap[i]  = ((y5_reg[i][1:0] == 2'd0) && !cent[i])
                    || (cent[i] && (yc5_reg[i][1:0] == 2'd0));
            ok6_next[i] = (m5_reg[i] >= 7'd1) && (m5_reg[i] <= 7'd12)
                       && (d5_reg[i] >= 7'd1)
                       && (d5_reg[i] <= {2'd0, month_len(m5_reg[i], leap[i])});
            base6_next[i] = p365_reg[i] + {11'd0, p5_reg[i][13:2]}
                          - {15'd0, pc5_reg[i]} + {17'd0, pc5_reg[i][7:2]};
            mo6_next[i] = days_before(m5_reg[i]) + {2'd0, d5_reg[i]}
                        + {8'd0, (m5_reg[i] > 7'd2) && leap[i]};

            // Stage 7: full day number.
            n7_next[i] = base6_reg[i] + {14'd0, mo6_reg[i]};
        end

        // Stage 8: distance between the two day numbers.
        if (n7_reg[0] > n7_reg[1])
            diff8_next = n7_reg[0] - n7_reg[1];
        else
            diff8_next = n7_reg[1] - n7_reg[0];

        // Stage 9: inclusive count with saturation, zero when invalid.
        cnt_wide = {1'b0, diff8_reg} + 24'd1;
        if (bad8_reg)
            cnt_next = '0;
        else if (cnt_wide > {2'b00, COUNT_MAX})
            cnt_next = COUNT_MAX;
        else
            cnt_next = cnt_wide[COUNT_W-1:0];
    end

    // Valid chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // Payload registers, all moving together.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg[0] <= s_tdata[26:0];
            x0_reg[1] <= s_tdata[53:27];
            for (int i = 0; i < 2; i++)
            begin
                x1_reg[i]    <= x0_reg[i];
                qe1_reg[i]   <= qe1_next[i];
                q2_reg[i]    <= q2_next[i];
                d2_reg[i]    <= d2_next[i];
                q3_reg[i]    <= q2_reg[i];
                qe3_reg[i]   <= qe3_next[i];
                d3_reg[i]    <= d2_reg[i];
                y4_reg[i]    <= y4_next[i];
                m4_reg[i]    <= m4_next[i];
                d4_reg[i]    <= d3_reg[i];
                y5_reg[i]    <= y4_reg[i];
                p5_reg[i]    <= p5_next[i];
                m5_reg[i]    <= m4_reg[i];
                d5_reg[i]    <= d4_reg[i];
                p365_reg[i]  <= p365_next[i];
                pc5_reg[i]   <= pc5_next[i];
                yc5_reg[i]   <= yc5_next[i];
                base6_reg[i] <= base6_next[i];
                mo6_reg[i]   <= mo6_next[i];
                ok6_reg[i]   <= ok6_next[i];
                n7_reg[i]    <= n7_next[i];
            end
            bad7_reg  <= !(ok6_reg[0] && ok6_reg[1]);
            bad8_reg  <= bad7_reg;
            diff8_reg <= diff8_next;
            cnt_reg   <= cnt_next;
            inv_reg   <= bad8_reg;
        end
    end

endmodule

>>> rtl/iddc_checker.sv
// ============================================================================
// iddc_checker
// Port-level checks for the inclusive date day count block.
// ============================================================================
`include "inclusive_date_day_count_macros.svh"

module iddc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,   // [21:0] day_count, [23:22] zero
    input logic        m_tuser    // [0] date_invalid
);

    // A stalled result beat stays offered.
    `IDDC_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result beat dropped")

    // Input is taken exactly when the output side can move.
    `IDDC_ASSERT_SAME(a_ready_link, 1'b1, s_tready == (!m_tvalid || m_tready), "ready mismatch")

    // An invalid result carries a zero count.
    `IDDC_ASSERT_SAME(a_invalid_zero, m_tvalid && m_tuser, m_tdata[21:0] == 22'd0, "bad count")

    // A valid result counts at least one day.
    `IDDC_ASSERT_SAME(a_valid_nonzero, m_tvalid && !m_tuser, m_tdata[21:0] != 22'd0, "zero count")

endmodule

bind inclusive_date_day_count iddc_checker u_iddc_checker (.*);

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// Testbench for inclusive_date_day_count
// Drives pairs of YYYYMMDD dates through the stream input, predicts the
// inclusive day count and the invalid flag for every accepted pair, and
// compares each output beat with the oldest prediction. The sender idles in
// bursts, and the receiver stalls on random patterns. One long receiver
// hold-off fills the pipeline so that the input stalls.
// ============================================================================
module testbench;
    import iddc_pkg::*;

    localparam int RUN_LIMIT    = 400000;
    localparam int RANDOM_PAIRS = 2000;
    localparam int HOLD_AFTER   = 500;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 30;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               invalid;
    } span_t;

    // Scoreboard: predicts the day count of each accepted pair and checks
    // output beats against the predictions in order.
    class span_board;
        span_t       due_q[$];
        int unsigned days_before[13];
        int          errors;
        int          checked;
        int          invalid_seen;
        int          saturated_seen;

        function new();
            days_before = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
            errors         = 0;
            checked        = 0;
            invalid_seen   = 0;
            saturated_seen = 0;
        endfunction

        function bit is_leap(input int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int unsigned days_in_month(input int unsigned y, input int unsigned m);
            if (m == 2)
                return is_leap(y) ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            return 31;
        endfunction

        // Splits a date into its decimal fields; returns 1 when it is a real day.
        function bit unpack_ymd(input logic [DATE_W-1:0] v, output int unsigned y,
                                output int unsigned m, output int unsigned d);
            int unsigned x;
            x = 32'(v);
            d = x % 100;
            x = x / 100;
            m = x % 100;
            y = x / 100;
            if (m < 1 || m > 12)
                return 0;
            return (d >= 1) && (d <= days_in_month(y, m));
        endfunction

        // Serial day of a valid date, with the year moved up by one whole
        // 400-year cycle less one (399) so that year zero stays positive.
        function int unsigned serial_day(input int unsigned y, input int unsigned m,
                                         input int unsigned d);
            int unsigned c;
            int unsigned n;
            c = y + 399;
            n = c * 365 + c / 4 - c / 100 + c / 400 + days_before[m] + d;
            if (m > 2 && is_leap(y))
                n = n + 1;
            return n;
        endfunction

        function void note_pair(input logic [DATE_W-1:0] a, input logic [DATE_W-1:0] b);
            span_t       e;
            int unsigned y1, m1, d1, y2, m2, d2;
            int unsigned n1, n2, span;
            bit          ok1, ok2;
            ok1 = unpack_ymd(a, y1, m1, d1);
            ok2 = unpack_ymd(b, y2, m2, d2);
            if (!(ok1 && ok2))
            begin
                e.count   = '0;
                e.invalid = 1'b1;
                invalid_seen++;
            end
            else
            begin
                n1   = serial_day(y1, m1, d1);
                n2   = serial_day(y2, m2, d2);
                span = ((n1 > n2) ? (n1 - n2) : (n2 - n1)) + 1;
                e.invalid = 1'b0;
                if (span > COUNT_MAX)
                begin
                    e.count = COUNT_MAX;
                    saturated_seen++;
                end
                else
                begin
                    e.count = span[COUNT_W-1:0];
                end
            end
            due_q.push_back(e);
        endfunction

        function void check_span(input logic [COUNT_W-1:0] count, input logic invalid);
            span_t e;
            if (due_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with nothing expected: count %0d invalid %0b",
                             $realtime, count, invalid);
                return;
            end
            e = due_q.pop_front();
            checked++;
            if (count !== e.count || invalid !== e.invalid)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch: count exp %0d got %0d, invalid exp %0b got %0b",
                             $realtime, e.count, count, e.invalid, invalid);
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // [26:0] date_first, [53:27] date_second, [55:54] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [21:0] day_count, [23:22] zero
    logic        m_tuser;   // [0] date_invalid

    span_board board;
    int        pairs_in;
    int        burst_left;
    int        cycle_count;
    bit        hold_done;

    inclusive_date_day_count u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Input beats become predictions, output beats are checked.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            board.note_pair(s_tdata[DATE_W-1:0], s_tdata[2*DATE_W-1:DATE_W]);
            pairs_in <= pairs_in + 1;
        end
        if (rst_n && m_tvalid && m_tready)
            board.check_span(m_tdata[COUNT_W-1:0], m_tuser);
    end

    // Run limit in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("Run limit of %0d cycles reached with %0d results outstanding.",
                     RUN_LIMIT, board.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [DATE_W-1:0] pack_date(input int unsigned y, input int unsigned m,
                                                    input int unsigned d);
        int unsigned v;
        v = y * 10000 + m * 100 + d;
        return v[DATE_W-1:0];
    endfunction

    // Mostly the four-digit range, with some year zero and far-out years.
    function automatic int unsigned pick_year();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 8)
            return $urandom_range(1, 9999);
        if (k == 8)
            return $urandom_range(0, 400);
        return $urandom_range(0, 13421);
    endfunction

    function automatic logic [DATE_W-1:0] pick_valid_date(input int unsigned y);
        int unsigned m;
        m = $urandom_range(1, 12);
        return pack_date(y, m, $urandom_range(1, board.days_in_month(y, m)));
    endfunction

    // Offers one pair and returns after the handshake, at the next falling edge.
    task automatic offer_pair(input logic [DATE_W-1:0] a, input logic [DATE_W-1:0] b);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: random stall patterns, plus one long hold-off once the
    // stream is well under way.
    initial
    begin : drain_side
        int span;
        int stall_pct;
        m_tready  = 1'b0;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            span = $urandom_range(10, 120);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 30;
                2: stall_pct = 70;
                default: stall_pct = 95;
            endcase
            if (!hold_done && pairs_in >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                stall_pct = 100;
                span      = HOLD_CYCLES;
            end
            repeat (span)
            begin
                @(negedge clk);
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Reset, directed pairs, random pairs, then drain and report.
    initial
    begin : stimulus
        logic [DATE_W-1:0] a;
        logic [DATE_W-1:0] b;
        logic [DATE_W-1:0] bad;
        int unsigned       y, m, d, len;
        board       = new();
        pairs_in    = 0;
        burst_left  = 0;
        cycle_count = 0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        rst_n       = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: equal dates, both orders, field extremes, leap rules,
        // bad months and days, year zero, far years and saturation.
        offer_pair(pack_date(2024, 1, 1), pack_date(2024, 1, 1));
        offer_pair(pack_date(1, 1, 1), pack_date(9999, 12, 31));
        offer_pair(pack_date(9999, 12, 31), pack_date(1, 1, 1));
        offer_pair(pack_date(2023, 12, 31), pack_date(2024, 1, 1));
        offer_pair(pack_date(0, 1, 1), pack_date(0, 1, 1));
        offer_pair(pack_date(0, 2, 29), pack_date(0, 3, 1));
        offer_pair(pack_date(1900, 2, 28), pack_date(1900, 3, 1));
        offer_pair(pack_date(1900, 2, 29), pack_date(1900, 3, 1));
        offer_pair(pack_date(2000, 2, 29), pack_date(2000, 3, 1));
        offer_pair(pack_date(2024, 2, 29), pack_date(2025, 2, 28));
        offer_pair(pack_date(2023, 2, 29), pack_date(2023, 3, 1));
        offer_pair(pack_date(2023, 0, 15), pack_date(2023, 1, 1));
        offer_pair(pack_date(2023, 1, 1), pack_date(2023, 13, 1));
        offer_pair(pack_date(2023, 1, 0), pack_date(2023, 1, 1));
        offer_pair(pack_date(2023, 4, 31), pack_date(2023, 5, 1));
        offer_pair(pack_date(2023, 1, 32), pack_date(2023, 1, 1));
        offer_pair(pack_date(2023, 99, 99), pack_date(2023, 6, 30));
        offer_pair('1, '0);
        offer_pair('0, pack_date(2024, 1, 1));
        offer_pair(pack_date(9999, 12, 31), pack_date(13421, 12, 31));
        offer_pair(pack_date(0, 1, 1), pack_date(13421, 12, 31));
        offer_pair(pack_date(13421, 12, 31), pack_date(1, 1, 1));
        offer_pair(27'd10101, 27'd99991231);

        // Random: mostly valid pairs, some near each other, month ends,
        // single bad fields and raw bit patterns.
        repeat (RANDOM_PAIRS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    a = pick_valid_date(pick_year());
                    b = pick_valid_date(pick_year());
                end
                5, 6:
                begin
                    y = pick_year();
                    a = pick_valid_date(y);
                    b = pick_valid_date((y < 13421) ? y + $urandom_range(0, 1) : y);
                end
                7:
                begin
                    y = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 134) * 100
                                                     : pick_year();
                    m = ($urandom_range(0, 1) != 0) ? 2 : $urandom_range(1, 12);
                    len = board.days_in_month(y, m);
                    a = pack_date(y, m, len + $urandom_range(0, 1));
                    b = pack_date((y < 13421) ? y + $urandom_range(0, 1) : y,
                                  m, $urandom_range(1, len));
                end
                8:
                begin
                    y = pick_year();
                    if ($urandom_range(0, 1) != 0)
                    begin
                        m = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(13, 99);
                        d = $urandom_range(0, 99);
                    end
                    else
                    begin
                        m   = $urandom_range(1, 12);
                        len = board.days_in_month(y, m);
                        d   = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(len + 1, 99);
                    end
                    bad = pack_date(y, m, d);
                    a   = pick_valid_date(pick_year());
                    if ($urandom_range(0, 1) != 0)
                    begin
                        b = bad;
                    end
                    else
                    begin
                        b = a;
                        a = bad;
                    end
                end
                default:
                begin
                    a = DATE_W'($urandom);
                    b = DATE_W'($urandom);
                end
            endcase
            offer_pair(a, b);
        end
        s_tvalid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d day counts from %0d date pairs: %0d invalid, %0d saturated.",
                 board.checked, pairs_in, board.invalid_seen, board.saturated_seen);
        $display("Receiver held off %0d cycles once; %0d mismatches, %0d results missing.",
                 HOLD_CYCLES, board.errors, board.pending());
        if (board.errors == 0 && board.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
